// ----- design/msq_pkg.sv -----
// ----------------------------------------------------------------------------
// msq_pkg
// Shared constants, codes and helpers for the mailbox service sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

  localparam int HALF_CHANNELS_DEF = 16;

  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_IRQ  = 3'd1;
  localparam logic [2:0] REQ_RESP = 3'd2;
  localparam logic [2:0] REQ_FILT = 3'd3;
  localparam logic [2:0] REQ_MAC  = 3'd4;
  localparam logic [2:0] REQ_HASH = 3'd5;

  localparam logic [1:0] ACC_WRITE = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_RING  = 2'd2;

  localparam logic [7:0]  OP_RD    = 8'hA0;
  localparam logic [7:0]  OP_WR    = 8'hA1;
  localparam logic [31:0] HDR_BASE = 32'hDC00_0000;

  localparam logic [2:0] LK_SERVICE = 3'd0;
  localparam logic [2:0] LK_STATUS  = 3'd1;
  localparam logic [2:0] LK_FLAGS   = 3'd2;
  localparam logic [2:0] LK_CHANQ   = 3'd3;
  localparam logic [2:0] LK_CHANACK = 3'd4;

  localparam logic [1:0] RP_NONE   = 2'd0;
  localparam logic [1:0] RP_STATUS = 2'd1;
  localparam logic [1:0] RP_CHAN   = 2'd2;

  localparam logic [1:0] PH_SERVICE = 2'd0;
  localparam logic [1:0] PH_CLEAR   = 2'd1;
  localparam logic [1:0] PH_QUERY   = 2'd2;
  localparam logic [1:0] PH_ACK     = 2'd3;

  localparam logic [5:0]  STATUS_WORDS = 6'd15;
  localparam logic [31:0] STATUS_MASK  = 32'h0000_7FFF;
  localparam logic [31:0] CHAN_BASE    = 32'h2100_0000;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] idx;
  } wg_sel_t;

  function automatic logic [31:0] status_addr(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h0000_0000;
      5'd1:    a = 32'h2000_0000;
      5'd2:    a = 32'h2001_0000;
      5'd3:    a = 32'h0100_0000;
      5'd4:    a = 32'h0101_0000;
      5'd5:    a = 32'h0102_0000;
      5'd6:    a = 32'h0103_0000;
      5'd7:    a = 32'h0140_0000;
      5'd8:    a = 32'h0145_0000;
      5'd9:    a = 32'h0146_0000;
      5'd10:   a = 32'h0147_0000;
      5'd11:   a = 32'h0141_0000;
      5'd12:   a = 32'h0142_0000;
      5'd13:   a = 32'h0143_0000;
      5'd14:   a = 32'h0144_0000;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- design/mailbox_service_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// mailbox_service_sequencer_core
// Host-side mailbox sequencer: ticks drive command runs, one access a cycle.
//
//   channel | ports               | direction | transfer
//   in_     | req_type .. value   | input     | in_valid & in_ready
//   out_    | access .. filter    | output    | out_valid & out_ready
//
// Non-tick items are taken in the idle state. A tick passes a done step,
// then either issues read requests or selects a write list, and then makes
// up to 34 mailbox accesses, one access list entry per cycle.
// Output stalls hold the sequencer. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mailbox_service_sequencer_core #(
  parameter int HALF_CHANNELS = msq_pkg::HALF_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic        in_doorbell_busy,
  input  wire logic        in_notify_bit,
  input  wire logic        in_done_bit,
  input  wire logic [15:0] in_response_word,
  input  wire logic [63:0] in_set_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_access_kind,
  output logic [5:0]       out_mailbox_slot,
  output logic [31:0]      out_write_data,
  output logic             out_last_of_run,
  output logic             out_status_valid,
  output logic [31:0]      out_sync_map,
  output logic [15:0]      out_availability,
  output logic [15:0]      out_packet_bandwidth,
  output logic [15:0]      out_node_address,
  output logic [15:0]      out_node_position,
  output logic [7:0]       out_filter_now
);

  localparam logic [15:0] HALF_MASK = 16'((33'(1) << HALF_CHANNELS) - 33'(1));
  localparam logic [31:0] CH_MASK   = {HALF_MASK, HALF_MASK};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_WRSEL = 3'd2;
  localparam logic [2:0] ST_RDREQ = 3'd3;
  localparam logic [2:0] ST_WLIST = 3'd4;
  localparam logic [2:0] ST_HDR   = 3'd5;
  localparam logic [2:0] ST_RING  = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  rp_r, rp_nxt;
  logic [5:0]  aw_r, aw_nxt;
  logic        notify_r, notify_nxt;
  logic        done_r, done_nxt;
  logic [15:0] event_r, event_nxt;
  logic [31:0] dma_r, dma_nxt;
  logic [31:0] syncnow_r, syncnow_nxt;
  logic [31:0] sticky_r, sticky_nxt;
  logic [15:0] sw0_r, sw0_nxt, sw1_r, sw1_nxt, sw2_r, sw2_nxt, sw3_r, sw3_nxt;
  logic [7:0]  filt_r, filt_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [2:0]  marks_r, marks_nxt;
  logic        valid_r, valid_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] wmask_r, wmask_nxt;
  logic [31:0] qmask_r, qmask_nxt;
  logic [2:0]  lkind_r, lkind_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [7:0]  op_r, op_nxt;

  logic        ov_r;
  logic [1:0]  okind_r;
  logic [5:0]  oslot_r;
  logic [31:0] odata_r;
  logic        olast_r;
  logic        ostat_r;
  logic [31:0] osync_r;
  logic [15:0] osw0_r, osw1_r, osw2_r, osw3_r;
  logic [7:0]  ofilt_r;

  logic        emit;
  logic [1:0]  e_kind;
  logic [5:0]  e_slot;
  logic [31:0] e_data;
  logic        e_last;
  logic        can_emit;
  logic        in_fire;

  logic [4:0]  pk_idx;
  logic [31:0] pk_rest;
  logic        pk_last;
  logic [4:0]  qk_idx;
  logic [31:0] qk_rest;
  logic        qk_last;
  msq_pkg::wg_sel_t wsel;
  logic [31:0] wdata;
  logic [5:0]  kfull;
  logic [31:0] m_svc;
  logic [31:0] m_chan;
  logic [5:0]  cnt_inc;

  msq_pick u_pick (.mask(wmask_r), .idx(pk_idx), .rest(pk_rest), .last(pk_last));
  msq_pick u_qpick (.mask(qmask_r), .idx(qk_idx), .rest(qk_rest), .last(qk_last));

  assign wsel.kind = lkind_r;
  assign wsel.idx  = pk_idx;

  msq_wordgen u_wordgen (
    .sel(wsel), .filt(filt_r), .mac(mac_r), .hash(hash_r), .dma(dma_r), .data(wdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign can_emit = !ov_r || out_ready;
  assign kfull    = msq_pkg::STATUS_WORDS - aw_r;
  assign m_svc    = {22'd0, {4{marks_r[2]}}, {3{marks_r[1]}}, marks_r[0], {2{event_r[5]}}};
  assign m_chan   = dma_r & CH_MASK;
  assign cnt_inc  = cnt_r + 6'd1;

  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r; rp_nxt = rp_r; aw_nxt = aw_r;
    notify_nxt = notify_r; done_nxt = done_r; event_nxt = event_r; dma_nxt = dma_r;
    syncnow_nxt = syncnow_r; sticky_nxt = sticky_r;
    sw0_nxt = sw0_r; sw1_nxt = sw1_r; sw2_nxt = sw2_r; sw3_nxt = sw3_r;
    filt_nxt = filt_r; mac_nxt = mac_r; hash_nxt = hash_r; marks_nxt = marks_r;
    valid_nxt = valid_r; busy_nxt = busy_r; wmask_nxt = wmask_r; qmask_nxt = qmask_r;
    lkind_nxt = lkind_r; cnt_nxt = cnt_r; op_nxt = op_r;
    emit = 1'b0; e_kind = msq_pkg::ACC_WRITE; e_slot = 6'd0; e_data = 32'd0; e_last = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req_type)
            msq_pkg::REQ_TICK: begin
              busy_nxt  = in_doorbell_busy;
              state_nxt = ST_DONE;
            end
            msq_pkg::REQ_IRQ: begin
              notify_nxt = notify_r | in_notify_bit;
              done_nxt   = done_r | in_done_bit;
            end
            msq_pkg::REQ_RESP: begin
              if (aw_r != 6'd0 && rp_r != msq_pkg::RP_NONE) begin
                if (rp_r == msq_pkg::RP_STATUS) begin
                  case (kfull)
                    6'd0:  event_nxt = in_response_word;
                    6'd1:  dma_nxt[15:0] = in_response_word;
                    6'd2:  dma_nxt[31:16] = in_response_word;
                    6'd3:  sw0_nxt = in_response_word;
                    6'd4:  sw1_nxt = in_response_word;
                    6'd5:  sw2_nxt = in_response_word;
                    6'd6:  sw3_nxt = in_response_word;
                    6'd7: begin
                      filt_nxt = in_response_word[7:0];
                      marks_nxt[0] = 1'b0;
                    end
                    6'd8:  mac_nxt[47:32] = in_response_word;
                    6'd9:  mac_nxt[31:16] = in_response_word;
                    6'd10: begin
                      mac_nxt[15:0] = in_response_word;
                      marks_nxt[1] = 1'b0;
                    end
                    6'd11: hash_nxt[63:48] = in_response_word;
                    6'd12: hash_nxt[47:32] = in_response_word;
                    6'd13: hash_nxt[31:16] = in_response_word;
                    6'd14: begin
                      hash_nxt[15:0] = in_response_word;
                      marks_nxt[2] = 1'b0;
                    end
                    default: ;
                  endcase
                end else begin
                  if (in_response_word[0]) begin
                    syncnow_nxt = syncnow_r | (32'd1 << qk_idx);
                  end
                  qmask_nxt = qk_rest;
                end
                aw_nxt = aw_r - 6'd1;
                if (aw_r == 6'd1) begin
                  if (rp_r == msq_pkg::RP_STATUS) begin
                    valid_nxt = 1'b1;
                    phase_nxt = (dma_nxt != 32'd0) ? msq_pkg::PH_CLEAR : msq_pkg::PH_SERVICE;
                  end else begin
                    sticky_nxt = sticky_r | syncnow_nxt;
                    phase_nxt = (syncnow_nxt != 32'd0) ? msq_pkg::PH_ACK
                                                       : msq_pkg::PH_SERVICE;
                  end
                  rp_nxt = msq_pkg::RP_NONE;
                  aw_nxt = 6'd0;
                end
              end
            end
            msq_pkg::REQ_FILT: begin
              filt_nxt = in_set_value[7:0];
              marks_nxt[0] = 1'b1;
            end
            msq_pkg::REQ_MAC: begin
              mac_nxt = in_set_value[47:0];
              marks_nxt[1] = 1'b1;
            end
            msq_pkg::REQ_HASH: begin
              hash_nxt = in_set_value;
              marks_nxt[2] = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_DONE: begin
        state_nxt = ST_WRSEL;
        if (done_r) begin
          done_nxt = 1'b0;
          if (rp_r != msq_pkg::RP_NONE && aw_r == 6'd0) begin
            cnt_nxt = 6'd0;
            if (rp_r == msq_pkg::RP_STATUS) begin
              state_nxt = ST_RDREQ;
            end else begin
              syncnow_nxt = 32'd0;
              wmask_nxt   = m_chan;
              qmask_nxt   = m_chan;
              if (m_chan != 32'd0) begin
                state_nxt = ST_RDREQ;
              end else begin
                phase_nxt = msq_pkg::PH_SERVICE;
                rp_nxt    = msq_pkg::RP_NONE;
              end
            end
          end
        end
      end

      ST_WRSEL: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = 6'd0;
        if (rp_r == msq_pkg::RP_NONE && !busy_r) begin
          case (phase_r)
            msq_pkg::PH_SERVICE: begin
              marks_nxt    = 3'd0;
              event_nxt[5] = 1'b0;
              if (m_svc != 32'd0) begin
                wmask_nxt = m_svc;
                lkind_nxt = msq_pkg::LK_SERVICE;
                op_nxt    = msq_pkg::OP_WR;
                state_nxt = ST_WLIST;
              end else if (notify_r) begin
                notify_nxt = 1'b0;
                rp_nxt     = msq_pkg::RP_STATUS;
                aw_nxt     = 6'd0;
                wmask_nxt  = msq_pkg::STATUS_MASK;
                lkind_nxt  = msq_pkg::LK_STATUS;
                op_nxt     = msq_pkg::OP_RD;
                state_nxt  = ST_WLIST;
              end
            end
            msq_pkg::PH_CLEAR: begin
              wmask_nxt = 32'd3;
              lkind_nxt = msq_pkg::LK_FLAGS;
              op_nxt    = msq_pkg::OP_WR;
              phase_nxt = msq_pkg::PH_QUERY;
              state_nxt = ST_WLIST;
            end
            msq_pkg::PH_QUERY: begin
              rp_nxt    = msq_pkg::RP_CHAN;
              aw_nxt    = 6'd0;
              wmask_nxt = m_chan;
              lkind_nxt = msq_pkg::LK_CHANQ;
              op_nxt    = msq_pkg::OP_RD;
              if (m_chan != 32'd0) state_nxt = ST_WLIST;
            end
            default: begin
              phase_nxt = msq_pkg::PH_SERVICE;
              wmask_nxt = syncnow_r;
              lkind_nxt = msq_pkg::LK_CHANACK;
              op_nxt    = msq_pkg::OP_WR;
              if (syncnow_r != 32'd0) state_nxt = ST_WLIST;
            end
          endcase
        end
      end

      ST_RDREQ: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_kind  = msq_pkg::ACC_READ;
          e_slot  = cnt_inc;
          cnt_nxt = cnt_inc;
          if (rp_r == msq_pkg::RP_STATUS) begin
            e_last = (cnt_inc == msq_pkg::STATUS_WORDS);
          end else begin
            e_last    = pk_last;
            wmask_nxt = pk_rest;
          end
          if (e_last) begin
            aw_nxt    = cnt_inc;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_WLIST: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_slot    = cnt_inc;
          e_data    = wdata;
          cnt_nxt   = cnt_inc;
          wmask_nxt = pk_rest;
          if (pk_last) state_nxt = ST_HDR;
        end
      end

      ST_HDR: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_data    = msq_pkg::HDR_BASE | {8'd0, op_r, 16'd0} | {16'd0, 2'd0, cnt_r, 8'd0};
          state_nxt = ST_RING;
        end
      end

      ST_RING: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_kind    = msq_pkg::ACC_RING;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; phase_r <= msq_pkg::PH_SERVICE; rp_r <= msq_pkg::RP_NONE;
      aw_r <= 6'd0; notify_r <= 1'b1; done_r <= 1'b0; event_r <= 16'd0;
      dma_r <= 32'd0; syncnow_r <= 32'd0; sticky_r <= 32'd0;
      sw0_r <= 16'd0; sw1_r <= 16'd0; sw2_r <= 16'd0; sw3_r <= 16'd0;
      filt_r <= 8'd0; mac_r <= 48'd0; hash_r <= 64'd0; marks_r <= 3'd0;
      valid_r <= 1'b0; busy_r <= 1'b0; wmask_r <= 32'd0; qmask_r <= 32'd0;
      lkind_r <= msq_pkg::LK_SERVICE; cnt_r <= 6'd0; op_r <= msq_pkg::OP_WR;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; phase_r <= phase_nxt; rp_r <= rp_nxt; aw_r <= aw_nxt;
      notify_r <= notify_nxt; done_r <= done_nxt; event_r <= event_nxt;
      dma_r <= dma_nxt; syncnow_r <= syncnow_nxt; sticky_r <= sticky_nxt;
      sw0_r <= sw0_nxt; sw1_r <= sw1_nxt; sw2_r <= sw2_nxt; sw3_r <= sw3_nxt;
      filt_r <= filt_nxt; mac_r <= mac_nxt; hash_r <= hash_nxt; marks_r <= marks_nxt;
      valid_r <= valid_nxt; busy_r <= busy_nxt; wmask_r <= wmask_nxt; qmask_r <= qmask_nxt;
      lkind_r <= lkind_nxt; cnt_r <= cnt_nxt; op_r <= op_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      okind_r <= e_kind; oslot_r <= e_slot; odata_r <= e_data; olast_r <= e_last;
      ostat_r <= valid_r; osync_r <= sticky_r;
      osw0_r <= sw0_r; osw1_r <= sw1_r; osw2_r <= sw2_r; osw3_r <= sw3_r;
      ofilt_r <= filt_r;
    end
  end

  assign out_valid            = ov_r;
  assign out_access_kind      = okind_r;
  assign out_mailbox_slot     = oslot_r;
  assign out_write_data       = odata_r;
  assign out_last_of_run      = olast_r;
  assign out_status_valid     = ostat_r;
  assign out_sync_map         = osync_r;
  assign out_availability     = osw0_r;
  assign out_packet_bandwidth = osw1_r;
  assign out_node_address     = osw2_r;
  assign out_node_position    = osw3_r;
  assign out_filter_now       = ofilt_r;

  a_ring_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_access_kind == msq_pkg::ACC_RING) |-> out_last_of_run)
    else $error("ring not last of run");

  a_rdreq_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDREQ) |-> (rp_r != msq_pkg::RP_NONE))
    else $error("read requests without pending read");

  a_aw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (aw_r <= 6'd32))
    else $error("awaiting count out of range");

  a_ring_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_access_kind == msq_pkg::ACC_RING) |-> (out_mailbox_slot == 6'd0))
    else $error("ring with nonzero slot");

  a_chan_last: assert property (@(posedge clk) disable iff (!rst_n)
    (rp_r == msq_pkg::RP_CHAN && aw_r == 6'd1) |-> qk_last)
    else $error("channel query list out of step");

endmodule

`default_nettype wire

// ----- design/msq_pick.sv -----
// ----------------------------------------------------------------------------
// msq_pick
// Lowest set bit of a work mask: its index and the mask with it cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_pick (
  input  wire logic [31:0] mask,
  output logic      [4:0]  idx,
  output logic      [31:0] rest,
  output logic             last
);

  always_comb begin
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (mask[i]) begin
        idx = 5'(i);
      end
    end
  end

  assign rest = mask & (mask - 32'd1);
  assign last = (rest == 32'd0);

endmodule

`default_nettype wire

// ----- design/msq_wordgen.sv -----
// ----------------------------------------------------------------------------
// msq_wordgen
// Mailbox write word for one entry of the active command list.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_wordgen (
  input  wire msq_pkg::wg_sel_t sel,
  input  wire logic [7:0]       filt,
  input  wire logic [47:0]      mac,
  input  wire logic [63:0]      hash,
  input  wire logic [31:0]      dma,
  output logic      [31:0]      data
);

  logic [31:0] chan_word;

  assign chan_word = msq_pkg::CHAN_BASE + {7'd0, sel.idx, 20'd0};

  always_comb begin
    data = 32'd0;
    case (sel.kind)
      msq_pkg::LK_SERVICE: begin
        case (sel.idx)
          5'd0:    data = 32'h0000_0020;
          5'd1:    data = 32'h2002_0001;
          5'd2:    data = 32'h0140_0000 | {24'd0, filt};
          5'd3:    data = 32'h0145_0000 | {16'd0, mac[47:32]};
          5'd4:    data = 32'h0146_0000 | {16'd0, mac[31:16]};
          5'd5:    data = 32'h0147_0000 | {16'd0, mac[15:0]};
          5'd6:    data = 32'h0141_0000 | {16'd0, hash[63:48]};
          5'd7:    data = 32'h0142_0000 | {16'd0, hash[47:32]};
          5'd8:    data = 32'h0143_0000 | {16'd0, hash[31:16]};
          5'd9:    data = 32'h0144_0000 | {16'd0, hash[15:0]};
          default: data = 32'd0;
        endcase
      end
      msq_pkg::LK_STATUS:  data = msq_pkg::status_addr(sel.idx);
      msq_pkg::LK_FLAGS: begin
        if (sel.idx == 5'd0) begin
          data = 32'h2000_0000 | {16'd0, dma[15:0]};
        end else begin
          data = 32'h2001_0000 | {16'd0, dma[31:16]};
        end
      end
      msq_pkg::LK_CHANQ:   data = chan_word;
      msq_pkg::LK_CHANACK: data = chan_word | 32'd1;
      default:             data = 32'd0;
    endcase
  end

endmodule

`default_nettype wire
